FILE: design/edf_pkg.sv
package edf_pkg;

	localparam int          TASK_COUNT_DEF     = 4;
	localparam logic [6:0]  TOP_PRIORITY_RESET = 7'd25;
	localparam logic [7:0]  PRIO_RESERVED      = 8'd2;
	localparam logic [7:0]  PRIO_MAX           = 8'd63;

	localparam logic CMD_UPDATE   = 1'b0;
	localparam logic CMD_SCHEDULE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  task_id;
		logic [31:0] release_tick;
		logic [31:0] deadline_ticks;
		logic [31:0] current_tick;
	} edf_in_t;

	typedef struct packed {
		logic [1:0] task_id_out;
		logic [5:0] priority_res;
		logic [1:0] rank;
		logic       last;
	} edf_out_t;

	typedef struct packed {
		logic        wen;
		logic [1:0]  task_id;
		logic [31:0] release_tick;
		logic [31:0] deadline_ticks;
		logic [31:0] current_tick;
	} edf_upd_t;

	function automatic logic [5:0] prio_for_rank(input logic [6:0] top, input logic [7:0] rnk);
		logic [7:0] need;
		logic [7:0] diff;
		need = rnk + PRIO_RESERVED;
		diff = {1'b0, top} - need;
		if ({1'b0, top} < need)
			return 6'd0;
		else if (diff > PRIO_MAX)
			return PRIO_MAX[5:0];
		else
			return diff[5:0];
	endfunction

endpackage

FILE: design/edf_slack_file.sv
module edf_slack_file import edf_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edf_upd_t                      upd,
	input  logic [$clog2(TASK_COUNT)-1:0] rd_idx,
	output logic [31:0]                   rd_slack
);

	localparam int IW = $clog2(TASK_COUNT);

	logic [31:0]   slack_q [TASK_COUNT];
	logic [IW+1:0] id_wide;
	logic          id_ok;
	logic [IW-1:0] wr_idx;
	logic [31:0]   new_slack;

	assign id_wide   = (IW+2)'(upd.task_id);
	assign id_ok     = id_wide < (IW+2)'(TASK_COUNT);
	assign wr_idx    = id_wide[IW-1:0];
	assign new_slack = upd.release_tick + upd.deadline_ticks - upd.current_tick;
	assign rd_slack  = slack_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++)
				slack_q[i] <= '0;
		end else if (upd.wen && id_ok) begin
			slack_q[wr_idx] <= new_slack;
		end
	end

endmodule

FILE: design/edf_rank_seq.sv
module edf_rank_seq import edf_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [6:0]                    top_priority,
	output logic [$clog2(TASK_COUNT)-1:0] rd_idx,
	input  logic [31:0]                   rd_slack,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output edf_out_t                      out_data
);

	localparam int            IW       = $clog2(TASK_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(TASK_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           rank_q;
	logic [TASK_COUNT-1:0]   done_q;
	logic                    have_q;
	logic [31:0]             best_q;
	logic [IW-1:0]           best_id_q;
	logic                    out_valid_q;
	edf_out_t                out_data_q;
	logic                    out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign busy      = (state_q != ST_IDLE);
	assign rd_idx    = idx_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rank_q      <= '0;
			done_q      <= '0;
			have_q      <= 1'b0;
			best_q      <= '0;
			best_id_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						rank_q  <= '0;
						done_q  <= '0;
						have_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!done_q[idx_q] && (!have_q || rd_slack < best_q)) begin
						best_q    <= rd_slack;
						best_id_q <= idx_q;
						have_q    <= 1'b1;
					end
					if (idx_q == LAST_IDX)
						state_q <= ST_EMIT;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q             <= 1'b1;
						out_data_q.task_id_out  <= 2'(best_id_q);
						out_data_q.priority_res <= prio_for_rank(top_priority, 8'(rank_q));
						out_data_q.rank         <= 2'(rank_q);
						out_data_q.last         <= (rank_q == LAST_IDX);
						done_q[best_id_q]       <= 1'b1;
						have_q                  <= 1'b0;
						idx_q                   <= '0;
						if (rank_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							rank_q  <= rank_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= LAST_IDX)
		else $error("rank counter past last task");

	a_emit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (have_q && !done_q[best_id_q]))
		else $error("emit without a fresh pick");

	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ($countones(done_q) == int'(rank_q)))
		else $error("ranked task count out of step with rank");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && rank_q == LAST_IDX) |=>
		(state_q == ST_IDLE && out_valid_q && out_data_q.last))
		else $error("final transfer not flagged or run not ended");
`endif

endmodule

FILE: design/edf_deadline_rank_scheduler.sv
// schedule item: busy until every rank is scanned and emitted, plus output stalls
// results follow one per rank, each after a scan of all slack registers and the emit state
// each rank is one scan of the slack registers through one shared 32-bit comparator
// update item: written to the slack register at the transfer, no result; next item may follow in the next cycle
// a result stays in the output register while the next rank is scanned
// reset: all slack values zero, top_priority 25, no result pending
module edf_deadline_rank_scheduler import edf_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic     in_valid,
	output logic     in_stall,
	input  edf_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output edf_out_t out_data
);

	localparam int IW = $clog2(TASK_COUNT);

	logic [6:0]    top_priority_q;
	logic          in_xfer;
	logic          busy;
	edf_upd_t      upd;
	logic [IW-1:0] rd_idx;
	logic [31:0]   rd_slack;

	assign in_stall = busy;
	assign in_xfer  = in_valid && !busy;

	assign upd.wen            = in_xfer && (in_data.cmd == CMD_UPDATE);
	assign upd.task_id        = in_data.task_id;
	assign upd.release_tick   = in_data.release_tick;
	assign upd.deadline_ticks = in_data.deadline_ticks;
	assign upd.current_tick   = in_data.current_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_priority_q <= TOP_PRIORITY_RESET;
		end else if (cfg_we) begin
			top_priority_q <= cfg_wdata;
		end
	end

	edf_slack_file #(
		.TASK_COUNT(TASK_COUNT)
	) u_slack (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.rd_idx   (rd_idx),
		.rd_slack (rd_slack)
	);

	edf_rank_seq #(
		.TASK_COUNT(TASK_COUNT)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_xfer && (in_data.cmd == CMD_SCHEDULE)),
		.top_priority (top_priority_q),
		.rd_idx       (rd_idx),
		.rd_slack     (rd_slack),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule
